>>> rtl/cqsa_pkg.sv
// Package for the class quota slot allocator: pool size, field widths, codes,
// beat payload structs and the control structs shared between its modules.
// Depends on nothing; every other file of the block imports it.
`timescale 1ns / 1ps

package cqsa_pkg;

   localparam int POOL_SLOTS  = 8;
   localparam int SLOT_W      = (POOL_SLOTS > 1) ? $clog2(POOL_SLOTS) : 1;
   localparam int LIVE_W      = $clog2(POOL_SLOTS + 1);
   localparam int QUOTA_W     = 4;
   localparam int CMP_W       = (LIVE_W > QUOTA_W) ? LIVE_W : QUOTA_W;
   localparam int STAMP_W     = 16;
   localparam int CLASS_COUNT = 3;

   localparam logic [STAMP_W-1:0] STAMP_NONE = 16'hFFFF;

   localparam logic [1:0] OP_ALLOC   = 2'd0;
   localparam logic [1:0] OP_RELEASE = 2'd1;
   localparam logic [1:0] OP_CLEAR   = 2'd2;

   localparam logic [1:0] CLASS_STATUE   = 2'd0;
   localparam logic [1:0] CLASS_BLOCK    = 2'd1;
   localparam logic [1:0] CLASS_PLATFORM = 2'd2;
   localparam logic [1:0] CLASS_NONE     = 2'd3;

   localparam logic [1:0] STATUS_FREE  = 2'd0;
   localparam logic [1:0] STATUS_EVICT = 2'd1;
   localparam logic [1:0] STATUS_FAIL  = 2'd2;
   localparam logic [1:0] STATUS_DONE  = 2'd3;

   localparam logic [1:0] CSR_QUOTA_STATUE   = 2'd0;
   localparam logic [1:0] CSR_QUOTA_BLOCK    = 2'd1;
   localparam logic [1:0] CSR_QUOTA_PLATFORM = 2'd2;

   typedef enum logic [1:0] {
      S_IDLE,
      S_SCAN,
      S_DECIDE
   } state_type;

   typedef struct packed {
      logic [1:0] opcode;
      logic [1:0] entry_class;
      logic [2:0] slot_index;
   } req_type;

   typedef struct packed {
      logic [1:0] status;
      logic [2:0] granted_slot;
      logic [3:0] class_live_count;
   } rsp_type;

   typedef struct packed {
      logic               valid;
      logic [1:0]         cls;
      logic [STAMP_W-1:0] stamp;
   } slot_entry_type;

   typedef struct packed {
      logic               alloc_en;
      logic [SLOT_W-1:0]  alloc_idx;
      logic [1:0]         alloc_cls;
      logic [STAMP_W-1:0] alloc_stamp;
      logic               release_en;
      logic [SLOT_W-1:0]  release_idx;
      logic               clear_en;
   } table_wr_type;

   typedef struct packed {
      logic clear;
      logic step;
   } scan_ctl_type;

   typedef struct packed {
      logic [LIVE_W-1:0] live;
      logic              have_oldest;
      logic [SLOT_W-1:0] oldest_idx;
      logic              have_free;
      logic [SLOT_W-1:0] free_idx;
   } scan_result_type;

endpackage

>>> rtl/cqsa_slot_table.sv
// Slot table of the allocator: valid bits, class and stamp of every slot.
// One read port driven by the scan index and one write port; uses cqsa_pkg.
`timescale 1ns / 1ps

module cqsa_slot_table (
   input  logic                           clock,
   input  logic                           reset,
   input  cqsa_pkg::table_wr_type         wr,
   input  logic [cqsa_pkg::SLOT_W-1:0]    rd_idx,
   output cqsa_pkg::slot_entry_type       rd_entry
);
   import cqsa_pkg::*;

   logic [POOL_SLOTS-1:0] valid_ff;
   logic [1:0]            class_ff [POOL_SLOTS];
   logic [STAMP_W-1:0]    stamp_ff [POOL_SLOTS];

   always_ff @(posedge clock) begin
      if (reset || wr.clear_en) begin
         valid_ff <= '0;
      end else begin
         if (wr.alloc_en) begin
            valid_ff[wr.alloc_idx] <= 1'b1;
         end
         if (wr.release_en) begin
            valid_ff[wr.release_idx] <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (wr.alloc_en) begin
         class_ff[wr.alloc_idx] <= wr.alloc_cls;
         stamp_ff[wr.alloc_idx] <= wr.alloc_stamp;
      end
   end

   always_comb begin
      rd_entry.valid = valid_ff[rd_idx];
      rd_entry.cls   = class_ff[rd_idx];
      rd_entry.stamp = stamp_ff[rd_idx];
   end

endmodule

>>> rtl/cqsa_scan_unit.sv
// Scan unit: takes one slot per cycle while step is set and accumulates the live count,
// the oldest entry of the requested class and the lowest free slot; uses cqsa_pkg.
`timescale 1ns / 1ps

module cqsa_scan_unit (
   input  logic                           clock,
   input  cqsa_pkg::scan_ctl_type         ctl,
   input  cqsa_pkg::slot_entry_type       entry,
   input  logic [cqsa_pkg::SLOT_W-1:0]    entry_idx,
   input  logic [1:0]                     req_class,
   output cqsa_pkg::scan_result_type      result
);
   import cqsa_pkg::*;

   scan_result_type    acc_ff;
   scan_result_type    acc_in;
   logic [STAMP_W-1:0] oldest_stamp_ff;
   logic [STAMP_W-1:0] oldest_stamp_in;

   always_comb begin
      acc_in          = acc_ff;
      oldest_stamp_in = oldest_stamp_ff;
      if (ctl.clear) begin
         acc_in          = '0;
         oldest_stamp_in = STAMP_NONE;
      end else if (ctl.step) begin
         if (!entry.valid) begin
            if (!acc_ff.have_free) begin
               acc_in.have_free = 1'b1;
               acc_in.free_idx  = entry_idx;
            end
         end else if (entry.cls == req_class) begin
            acc_in.live = acc_ff.live + LIVE_W'(1);
            if (entry.stamp < oldest_stamp_ff) begin
               oldest_stamp_in    = entry.stamp;
               acc_in.oldest_idx  = entry_idx;
               acc_in.have_oldest = 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      acc_ff          <= acc_in;
      oldest_stamp_ff <= oldest_stamp_in;
   end

   assign result = acc_ff;

endmodule

>>> rtl/class_quota_slot_allocator.sv
// Top level of the class quota slot allocator: command handshake, quota registers, stamp
// counter and the sequencer over cqsa_slot_table and cqsa_scan_unit; uses cqsa_pkg.
// An allocate of a real class strobes its result after capture, a scan of every slot and
// decide. Other requests, and an allocate of CLASS_NONE, strobe in the cycle after start.
// busy covers an allocate in flight; a new start is taken in the strobe cycle. Results last
// one cycle. Synchronous reset empties the pool, zeroes the stamp and sets each quota to one.
`timescale 1ns / 1ps

module class_quota_slot_allocator (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   output logic                        busy,
   input  cqsa_pkg::req_type           req_payload,
   output logic                        rsp_valid,
   output cqsa_pkg::rsp_type           rsp_payload,
   input  logic                        csr_valid,
   output logic                        csr_ready,
   input  logic [1:0]                  csr_index,
   input  logic [3:0]                  csr_wdata
);
   import cqsa_pkg::*;

   state_type            state_ff, state_in;
   req_type              req_ff, req_in;
   logic [SLOT_W-1:0]    scan_idx_ff, scan_idx_in;
   logic [STAMP_W-1:0]   next_stamp_ff, next_stamp_in;
   logic [QUOTA_W-1:0]   quota_ff [CLASS_COUNT];
   logic                 rsp_valid_ff, rsp_valid_in;
   rsp_type              rsp_ff, rsp_in;

   table_wr_type         wr;
   slot_entry_type       entry;
   scan_ctl_type         scan_ctl;
   scan_result_type      scan_res;

   logic [QUOTA_W-1:0]   quota_sel;
   logic                 evict;
   logic [3:0]           live_sat;

   cqsa_slot_table u_table (
      .clock    (clock),
      .reset    (reset),
      .wr       (wr),
      .rd_idx   (scan_idx_ff),
      .rd_entry (entry)
   );

   cqsa_scan_unit u_scan (
      .clock     (clock),
      .ctl       (scan_ctl),
      .entry     (entry),
      .entry_idx (scan_idx_ff),
      .req_class (req_ff.entry_class),
      .result    (scan_res)
   );

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < CLASS_COUNT; i++) begin
            quota_ff[i] <= QUOTA_W'(1);
         end
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_QUOTA_STATUE:   quota_ff[0] <= csr_wdata;
            CSR_QUOTA_BLOCK:    quota_ff[1] <= csr_wdata;
            CSR_QUOTA_PLATFORM: quota_ff[2] <= csr_wdata;
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (req_ff.entry_class)
         CLASS_STATUE:   quota_sel = quota_ff[0];
         CLASS_BLOCK:    quota_sel = quota_ff[1];
         CLASS_PLATFORM: quota_sel = quota_ff[2];
         default:        quota_sel = quota_ff[0];
      endcase
      evict    = (CMP_W'(scan_res.live) >= CMP_W'(quota_sel)) && scan_res.have_oldest;
      live_sat = (CMP_W'(scan_res.live) > CMP_W'(4'hF)) ? 4'hF : 4'(scan_res.live);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         scan_idx_ff   <= '0;
         next_stamp_ff <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         scan_idx_ff   <= scan_idx_in;
         next_stamp_ff <= next_stamp_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff <= req_in;
      rsp_ff <= rsp_in;
   end

   always_comb begin
      state_in      = state_ff;
      req_in        = req_ff;
      scan_idx_in   = scan_idx_ff;
      next_stamp_in = next_stamp_ff;
      rsp_valid_in  = 1'b0;
      rsp_in        = rsp_ff;
      wr            = '0;
      scan_ctl      = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               req_in = req_payload;
               if (req_payload.opcode == OP_ALLOC && req_payload.entry_class != CLASS_NONE) begin
                  state_in       = S_SCAN;
                  scan_idx_in    = '0;
                  scan_ctl.clear = 1'b1;
               end else begin
                  rsp_valid_in            = 1'b1;
                  rsp_in.status           = (req_payload.opcode == OP_ALLOC) ?
                                            STATUS_FAIL : STATUS_DONE;
                  rsp_in.granted_slot     = '0;
                  rsp_in.class_live_count = '0;
                  if (req_payload.opcode == OP_RELEASE &&
                      int'(req_payload.slot_index) < POOL_SLOTS) begin
                     wr.release_en  = 1'b1;
                     wr.release_idx = SLOT_W'(req_payload.slot_index);
                  end
                  if (req_payload.opcode == OP_CLEAR) begin
                     wr.clear_en   = 1'b1;
                     next_stamp_in = '0;
                  end
               end
            end
         end
         S_SCAN: begin
            scan_ctl.step = 1'b1;
            if (scan_idx_ff == SLOT_W'(POOL_SLOTS - 1)) begin
               state_in = S_DECIDE;
            end else begin
               scan_idx_in = scan_idx_ff + SLOT_W'(1);
            end
         end
         S_DECIDE: begin
            state_in                = S_IDLE;
            rsp_valid_in            = 1'b1;
            rsp_in.class_live_count = live_sat;
            wr.alloc_cls            = req_ff.entry_class;
            wr.alloc_stamp          = next_stamp_ff;
            if (evict) begin
               rsp_in.status       = STATUS_EVICT;
               rsp_in.granted_slot = 3'(scan_res.oldest_idx);
               wr.alloc_en         = 1'b1;
               wr.alloc_idx        = scan_res.oldest_idx;
            end else if (scan_res.have_free) begin
               rsp_in.status       = STATUS_FREE;
               rsp_in.granted_slot = 3'(scan_res.free_idx);
               wr.alloc_en         = 1'b1;
               wr.alloc_idx        = scan_res.free_idx;
            end else begin
               rsp_in.status       = STATUS_FAIL;
               rsp_in.granted_slot = '0;
            end
            if (wr.alloc_en) begin
               next_stamp_in = next_stamp_ff + STAMP_W'(1);
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   assign busy        = (state_ff != S_IDLE);
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   // The last slot of a scan always hands over to the decision cycle.
   a_scan_ends: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SCAN && scan_idx_ff == SLOT_W'(POOL_SLOTS - 1)) |=> state_ff == S_DECIDE)
      else $error("scan did not end in the decision cycle");

   a_decide_strobe: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_DECIDE |=> (rsp_valid && state_ff == S_IDLE))
      else $error("decision cycle gave no result beat");

   a_strobe_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy)
      else $error("result beat while busy");

   a_evict_live: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_payload.status == STATUS_EVICT) |-> rsp_payload.class_live_count != 4'd0)
      else $error("eviction with no live entry of the class");

   a_short_op: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && req_payload.opcode != OP_ALLOC) |=>
      (rsp_valid && rsp_payload.status == STATUS_DONE))
      else $error("release, clear or no-op did not finish in one cycle");

endmodule

>>> dv/cqsa_response_checker.sv
// Checker for the class quota slot allocator: watches the command, result and
// quota register channels, predicts every result beat and compares it field by field.
// Depends on cqsa_pkg for the beat structs, pool size and codes.
`timescale 1ns / 1ps

module cqsa_response_checker (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic              busy,
   input  cqsa_pkg::req_type req_payload,
   input  logic              rsp_valid,
   input  cqsa_pkg::rsp_type rsp_payload,
   input  logic              csr_valid,
   input  logic              csr_ready,
   input  logic [1:0]        csr_index,
   input  logic [3:0]        csr_wdata,
   output int                mismatches,
   output int                outstanding,
   output int                requests_seen,
   output int                results_checked
);
   import cqsa_pkg::*;

   localparam int MAX_PRINTED = 40;

   logic               slot_live   [POOL_SLOTS];
   logic [1:0]         slot_owner  [POOL_SLOTS];
   logic [STAMP_W-1:0] slot_age    [POOL_SLOTS];
   logic [STAMP_W-1:0] stamp_count;
   logic [QUOTA_W-1:0] class_quota [CLASS_COUNT];
   rsp_type            expected_grants [$];

   initial begin
      mismatches      = 0;
      outstanding     = 0;
      requests_seen   = 0;
      results_checked = 0;
   end

   task automatic report_mismatch(input string what, input int got, input int want);
      if (mismatches < MAX_PRINTED) begin
         $display("[%0t] result beat %0d: %s is %0d, expected %0d",
                  $time, results_checked, what, got, want);
      end
      mismatches++;
   endtask

   function automatic rsp_type predict_grant(input req_type item);
      rsp_type            result;
      int                 live;
      int                 oldest_slot;
      int                 free_slot;
      int                 pick;
      logic [STAMP_W-1:0] oldest_age;
      result        = '0;
      result.status = STATUS_DONE;
      if (item.opcode == OP_ALLOC) begin
         if (item.entry_class == CLASS_NONE) begin
            result.status = STATUS_FAIL;
            return result;
         end
         live        = 0;
         oldest_slot = -1;
         free_slot   = -1;
         oldest_age  = STAMP_NONE;
         for (int i = 0; i < POOL_SLOTS; i++) begin
            if (!slot_live[i]) begin
               if (free_slot < 0) begin
                  free_slot = i;
               end
            end else if (slot_owner[i] == item.entry_class) begin
               live++;
               if (slot_age[i] < oldest_age) begin
                  oldest_age  = slot_age[i];
                  oldest_slot = i;
               end
            end
         end
         result.class_live_count = (live > 15) ? 4'd15 : 4'(live);
         if (live >= class_quota[item.entry_class] && oldest_slot >= 0) begin
            pick          = oldest_slot;
            result.status = STATUS_EVICT;
         end else if (free_slot >= 0) begin
            pick          = free_slot;
            result.status = STATUS_FREE;
         end else begin
            result.status = STATUS_FAIL;
            return result;
         end
         result.granted_slot = 3'(pick);
         slot_live[pick]     = 1'b1;
         slot_owner[pick]    = item.entry_class;
         slot_age[pick]      = stamp_count;
         stamp_count         = stamp_count + 1'b1;
      end else if (item.opcode == OP_RELEASE) begin
         if (item.slot_index < POOL_SLOTS) begin
            slot_live[item.slot_index] = 1'b0;
         end
      end else if (item.opcode == OP_CLEAR) begin
         for (int i = 0; i < POOL_SLOTS; i++) begin
            slot_live[i] = 1'b0;
         end
         stamp_count = '0;
      end
      return result;
   endfunction

   always @(posedge clock) begin : watch
      rsp_type want;
      if (reset) begin
         for (int i = 0; i < POOL_SLOTS; i++) begin
            slot_live[i]  = 1'b0;
            slot_owner[i] = '0;
            slot_age[i]   = '0;
         end
         for (int c = 0; c < CLASS_COUNT; c++) begin
            class_quota[c] = 4'd1;
         end
         stamp_count = '0;
         expected_grants.delete();
      end else begin
         if (rsp_valid) begin
            if (expected_grants.size() == 0) begin
               report_mismatch("unexpected beat, status", rsp_payload.status, -1);
            end else begin
               want = expected_grants.pop_front();
               if (rsp_payload.status !== want.status) begin
                  report_mismatch("status", rsp_payload.status, want.status);
               end
               if (rsp_payload.granted_slot !== want.granted_slot) begin
                  report_mismatch("granted_slot", rsp_payload.granted_slot,
                                  want.granted_slot);
               end
               if (rsp_payload.class_live_count !== want.class_live_count) begin
                  report_mismatch("class_live_count", rsp_payload.class_live_count,
                                  want.class_live_count);
               end
               results_checked++;
            end
         end
         if (csr_valid && csr_ready && csr_index < CLASS_COUNT) begin
            class_quota[csr_index] = csr_wdata;
         end
         if (start && !busy) begin
            expected_grants.push_back(predict_grant(req_payload));
            requests_seen++;
         end
      end
      outstanding = expected_grants.size();
   end

endmodule

>>> dv/tb_class_quota_slot_allocator.sv
// Top of the class quota slot allocator testbench: clock, reset, command and
// quota register stimulus, and the verdict. Depends on cqsa_pkg, the block
// class_quota_slot_allocator and cqsa_response_checker, which does all checking.
`timescale 1ns / 1ps

module tb_class_quota_slot_allocator;
   import cqsa_pkg::*;

   localparam int RANDOM_ITEMS  = 1700;
   localparam int RANDOM_BLOCKS = 6;
   localparam int CYCLE_LIMIT   = 3_000_000;
   localparam int SETTLE_CYCLES = 20;

   localparam logic [1:0] OP_NONE    = 2'd3;
   localparam logic [1:0] CSR_UNUSED = 2'd3;

   logic       clock;
   logic       reset;
   logic       start;
   logic       busy;
   req_type    req_payload;
   logic       rsp_valid;
   rsp_type    rsp_payload;
   logic       csr_valid;
   logic       csr_ready;
   logic [1:0] csr_index;
   logic [3:0] csr_wdata;

   int mismatches;
   int outstanding;
   int requests_seen;
   int results_checked;
   int cycle_count = 0;
   int gap_pct;

   class_quota_slot_allocator dut (.*);

   cqsa_response_checker grant_checker (.*);

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles, %0d results still outstanding",
                  cycle_count, outstanding);
         $display("DONE: errors detected");
         $finish;
      end
   end

   task automatic send_beat(input req_type item);
      @(negedge clock);
      if ($urandom_range(99) < gap_pct) begin
         start <= 1'b0;
         @(negedge clock);
         while ($urandom_range(99) < gap_pct) @(negedge clock);
      end
      start       <= 1'b1;
      req_payload <= item;
      do @(posedge clock); while (busy);
   endtask

   task automatic issue(input logic [1:0] opcode, input logic [1:0] entry_class,
                        input logic [2:0] slot_index);
      req_type item;
      item.opcode      = opcode;
      item.entry_class = entry_class;
      item.slot_index  = slot_index;
      send_beat(item);
   endtask

   task automatic drain_requests();
      @(negedge clock);
      start <= 1'b0;
      while (outstanding != 0 || busy) @(negedge clock);
   endtask

   task automatic write_quota(input logic [1:0] index, input logic [3:0] wdata);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_wdata <= wdata;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   function automatic req_type random_request();
      req_type     item;
      int unsigned roll;
      roll             = $urandom_range(99);
      item.entry_class = 2'($urandom_range(2));
      item.slot_index  = 3'($urandom_range(7));
      if (roll < 60) begin
         item.opcode = OP_ALLOC;
      end else if (roll < 96) begin
         item.entry_class = 2'($urandom_range(3));
         if (roll < 88) begin
            item.opcode = OP_RELEASE;
         end else if (roll < 92) begin
            item.opcode = OP_CLEAR;
         end else begin
            item.opcode = OP_NONE;
         end
      end else begin
         item.opcode      = OP_ALLOC;
         item.entry_class = CLASS_NONE;
      end
      return item;
   endfunction

   initial begin
      reset       = 1'b1;
      start       = 1'b0;
      req_payload = '0;
      csr_valid   = 1'b0;
      csr_index   = CSR_QUOTA_STATUE;
      csr_wdata   = '0;
      gap_pct     = 11;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Reset quotas are one per class.
      issue(OP_ALLOC, CLASS_STATUE, 3'd0);
      issue(OP_ALLOC, CLASS_STATUE, 3'd7);
      issue(OP_ALLOC, CLASS_BLOCK, 3'd0);
      issue(OP_ALLOC, CLASS_PLATFORM, 3'd0);
      issue(OP_ALLOC, CLASS_NONE, 3'd7);
      issue(OP_NONE, CLASS_NONE, 3'd7);
      issue(OP_RELEASE, CLASS_STATUE, 3'd7);
      issue(OP_RELEASE, CLASS_NONE, 3'd0);
      issue(OP_CLEAR, CLASS_NONE, 3'd7);

      // A zero quota, a full quota and one above the pool size.
      drain_requests();
      write_quota(CSR_QUOTA_STATUE, 4'd0);
      write_quota(CSR_QUOTA_BLOCK, 4'd8);
      write_quota(CSR_QUOTA_PLATFORM, 4'd15);
      write_quota(CSR_UNUSED, 4'd15);
      issue(OP_ALLOC, CLASS_STATUE, 3'd0);
      issue(OP_ALLOC, CLASS_STATUE, 3'd0);
      repeat (7) issue(OP_ALLOC, CLASS_PLATFORM, 3'd0);
      issue(OP_ALLOC, CLASS_PLATFORM, 3'd0);
      issue(OP_ALLOC, CLASS_BLOCK, 3'd0);
      issue(OP_ALLOC, CLASS_STATUE, 3'd0);
      issue(OP_RELEASE, CLASS_BLOCK, 3'd7);
      issue(OP_ALLOC, CLASS_BLOCK, 3'd0);

      for (int b = 0; b < RANDOM_BLOCKS; b++) begin
         drain_requests();
         case (b)
            0: begin
               write_quota(CSR_QUOTA_STATUE, 4'd1);
               write_quota(CSR_QUOTA_BLOCK, 4'd2);
               write_quota(CSR_QUOTA_PLATFORM, 4'd3);
            end
            1: begin
               write_quota(CSR_QUOTA_STATUE, 4'd0);
               write_quota(CSR_QUOTA_BLOCK, 4'd8);
               write_quota(CSR_QUOTA_PLATFORM, 4'd15);
            end
            2: begin
               write_quota(CSR_QUOTA_STATUE, 4'd8);
               write_quota(CSR_QUOTA_BLOCK, 4'd0);
               write_quota(CSR_QUOTA_PLATFORM, 4'd8);
            end
            default: begin
               write_quota(CSR_QUOTA_STATUE, 4'($urandom_range(15)));
               write_quota(CSR_QUOTA_BLOCK, 4'($urandom_range(8)));
               write_quota(CSR_QUOTA_PLATFORM, 4'($urandom_range(8)));
            end
         endcase
         gap_pct = (b < 2) ? 11 : (b < 4) ? 64 : 0;
         repeat (RANDOM_ITEMS / RANDOM_BLOCKS) send_beat(random_request());
      end

      drain_requests();
      repeat (SETTLE_CYCLES) @(posedge clock);
      $display("Covered %0d requests and %0d result beats over six quota settings,",
               requests_seen, results_checked);
      $display("including zero and oversized quotas, releases, clears and unused codes.");
      if (mismatches == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule
